>>> rtl/hpcf_pkg.sv
// ----------------------------------------------------------------------------
// hpcf_pkg: shared types and constants for the haptic coupling force block
// Widths of the internal datapath, unit op codes and register indexes.
// ----------------------------------------------------------------------------
package hpcf_pkg;

  // datapath widths
  localparam int MAG_W    = 64;   // signed intermediates and force magnitudes
  localparam int ACC_W    = 96;   // 64 x 32 product accumulator
  localparam int MUL_W    = 32;   // shared multiplier operand width
  localparam int REG_W    = 31;   // stiffness, damping, force limit
  localparam int TICK_W   = 20;   // tick rate register
  localparam int OBJ_W    = 16;   // object id
  localparam int FORCE_W  = 32;   // force output

  // divide / square root unit: one result bit per cycle
  localparam int DS_ITERS = 32;
  localparam int DS_CNT_W = 5;

  // saturation magnitude of velocity and force terms: 2^62 - 1
  localparam logic [MAG_W-1:0] SAT_MAG = 64'h3FFF_FFFF_FFFF_FFFF;

  // divide / square root op codes
  localparam logic OP_DIV  = 1'b0;
  localparam logic OP_SQRT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_STIFFNESS  = 2'd0;
  localparam logic [1:0] REG_DAMPING    = 2'd1;
  localparam logic [1:0] REG_FORCE_LIM  = 2'd2;
  localparam logic [1:0] REG_TICK_RATE  = 2'd3;

  // command from the sequencer to the divide / square root unit
  typedef struct packed {
    logic start;
    logic op;
  } ds_ctrl_t;

endpackage

>>> rtl/hpcf_mul.sv
// ----------------------------------------------------------------------------
// hpcf_mul: shared 32 x 32 unsigned multiplier
// Product is registered; it is valid in the cycle after the operands.
// ----------------------------------------------------------------------------
module hpcf_mul (
  input  logic                             clk,
  input  logic [hpcf_pkg::MUL_W-1:0]       mul_a,
  input  logic [hpcf_pkg::MUL_W-1:0]       mul_b,
  output logic [2*hpcf_pkg::MUL_W-1:0]     mul_p
);
  import hpcf_pkg::*;

  logic [2*MUL_W-1:0] p_r;

  // registered product
  always_ff @(posedge clk) begin
    p_r <= {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
  end

  assign mul_p = p_r;

endmodule

>>> rtl/hpcf_divsqrt.sv
// ----------------------------------------------------------------------------
// hpcf_divsqrt: bit-serial integer square root and divider
// Shares one compare/subtract; produces one result bit per cycle.
// Square root: floor(sqrt(a)) of a 64-bit radicand.
// Divide: a / b where the quotient is known to fit in 32 bits.
// ----------------------------------------------------------------------------
module hpcf_divsqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hpcf_pkg::ds_ctrl_t            ctrl,
  input  logic [hpcf_pkg::MAG_W-1:0]    opa,
  input  logic [hpcf_pkg::MUL_W-1:0]    opb,
  output logic                          done,
  output logic [hpcf_pkg::MUL_W-1:0]    result
);
  import hpcf_pkg::*;

  localparam logic [DS_CNT_W-1:0] CNT_LAST = DS_CNT_W'(DS_ITERS - 1);

  logic                busy_r;
  logic                done_r;
  logic                op_r;
  logic [DS_CNT_W-1:0] cnt_r;
  logic [33:0]         rem_r;
  logic [MUL_W-1:0]    quo_r;
  logic [MAG_W-1:0]    src_r;
  logic [MUL_W-1:0]    dvs_r;

  logic [35:0]         cand;
  logic [35:0]         trial;
  logic [35:0]         diff;
  logic                ge;

  // trial subtract for the current bit
  always_comb begin
    if (op_r == OP_SQRT) begin
      cand  = {rem_r, src_r[MAG_W-1 -: 2]};
      trial = {2'b00, quo_r, 2'b01};
    end else begin
      cand  = {3'b000, rem_r[MUL_W-1:0], src_r[MAG_W-1]};
      trial = {4'b0000, dvs_r};
    end
    ge   = (cand >= trial);
    diff = cand - trial;
  end

  // iteration control and data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_LAST);
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= ctrl.op;
        quo_r  <= '0;
        dvs_r  <= opb;
        if (ctrl.op == OP_SQRT) begin
          rem_r <= '0;
          src_r <= opa;
        end else begin
          rem_r <= {2'b00, opa[MAG_W-1:MUL_W]};
          src_r <= {opa[MUL_W-1:0], {MUL_W{1'b0}}};
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[33:0] : cand[33:0];
        quo_r <= {quo_r[MUL_W-2:0], ge};
        src_r <= (op_r == OP_SQRT) ? {src_r[MAG_W-3:0], 2'b00} : {src_r[MAG_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done   = done_r;
  assign result = quo_r;

endmodule

>>> rtl/haptic_proxy_coupling_force.sv
// ----------------------------------------------------------------------------
// haptic_proxy_coupling_force: spring-damper coupling between proxy and tool
// Takes one transaction at a time: a new input is accepted only after the result
// is loaded into the output register, which is held back while a result stalls.
// Built on the shared 32x32 multiplier (9 wide products), up to 32 normalizing
// shifts and the bit-serial sqrt / divide unit (up to 4 ops: one sqrt, three divides).
// Reset (synchronous, rst_n low): registers to defaults, previous proxy to origin.
// ----------------------------------------------------------------------------
module haptic_proxy_coupling_force #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [hpcf_pkg::REG_W-1:0]       cfg_wdata,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [COORD_WIDTH-1:0]           in_tool_px,
  input  logic [COORD_WIDTH-1:0]           in_tool_py,
  input  logic [COORD_WIDTH-1:0]           in_tool_pz,
  input  logic [COORD_WIDTH-1:0]           in_tool_vx,
  input  logic [COORD_WIDTH-1:0]           in_tool_vy,
  input  logic [COORD_WIDTH-1:0]           in_tool_vz,
  input  logic                             in_in_contact,
  input  logic [COORD_WIDTH-1:0]           in_contact_cx,
  input  logic [COORD_WIDTH-1:0]           in_contact_cy,
  input  logic [COORD_WIDTH-1:0]           in_contact_cz,
  input  logic [hpcf_pkg::OBJ_W-1:0]       in_contact_object,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [hpcf_pkg::FORCE_W-1:0]     out_force_x,
  output logic [hpcf_pkg::FORCE_W-1:0]     out_force_y,
  output logic [hpcf_pkg::FORCE_W-1:0]     out_force_z,
  output logic [COORD_WIDTH-1:0]           out_proxy_x,
  output logic [COORD_WIDTH-1:0]           out_proxy_y,
  output logic [COORD_WIDTH-1:0]           out_proxy_z,
  output logic                             out_wrench_valid,
  output logic [hpcf_pkg::OBJ_W-1:0]       out_target_object
);
  import hpcf_pkg::*;

  // register defaults in the fixed-point format
  localparam logic [63:0] K_FULL = 64'd2000 << FRAC_BITS;
  localparam logic [63:0] D_FULL = 64'd28 << FRAC_BITS;
  localparam logic [63:0] L_FULL = 64'd15 << FRAC_BITS;
  localparam logic [REG_W-1:0]  K_RST    = K_FULL[REG_W-1:0];
  localparam logic [REG_W-1:0]  D_RST    = D_FULL[REG_W-1:0];
  localparam logic [REG_W-1:0]  L_RST    = L_FULL[REG_W-1:0];
  localparam logic [TICK_W-1:0] TICK_RST = TICK_W'(1000);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WSET   = 4'd1;
  localparam logic [3:0] S_WLO    = 4'd2;
  localparam logic [3:0] S_WHI    = 4'd3;
  localparam logic [3:0] S_WACC   = 4'd4;
  localparam logic [3:0] S_WFIN   = 4'd5;
  localparam logic [3:0] S_WUSE   = 4'd6;
  localparam logic [3:0] S_SHIFT  = 4'd7;
  localparam logic [3:0] S_SQI    = 4'd8;
  localparam logic [3:0] S_SQA    = 4'd9;
  localparam logic [3:0] S_CMP    = 4'd10;
  localparam logic [3:0] S_SQRT   = 4'd11;
  localparam logic [3:0] S_DMUL   = 4'd12;
  localparam logic [3:0] S_DSTART = 4'd13;
  localparam logic [3:0] S_DIV    = 4'd14;
  localparam logic [3:0] S_OUT    = 4'd15;

  // force terms per axis
  localparam logic [1:0] T_PV = 2'd0;   // proxy velocity
  localparam logic [1:0] T_SP = 2'd1;   // spring
  localparam logic [1:0] T_DM = 2'd2;   // damper

  localparam logic [1:0] AX_LAST = 2'd2;
  localparam logic [1:0] K_LIM   = 2'd3;

  function automatic logic [MAG_W-1:0] sx64(input logic [COORD_WIDTH-1:0] v);
    return {{(MAG_W-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
  endfunction

  // configuration registers
  logic [REG_W-1:0]       stiff_r;
  logic [REG_W-1:0]       damp_r;
  logic [REG_W-1:0]       limit_r;
  logic [TICK_W-1:0]      tick_r;

  // sequencer
  logic [3:0]             state_r;
  logic [1:0]             ax_r;
  logic [1:0]             term_r;
  logic [1:0]             k_r;

  // per-transaction operands
  logic [COORD_WIDTH-1:0] tool_r  [3];
  logic [COORD_WIDTH-1:0] tvel_r  [3];
  logic [COORD_WIDTH-1:0] proxy_r [3];
  logic [COORD_WIDTH-1:0] prev_r  [3];
  logic                   contact_r;
  logic [OBJ_W-1:0]       object_r;

  // wide multiply sub-sequence
  logic [MAG_W-1:0]       wmag_r;
  logic                   wneg_r;
  logic [ACC_W-1:0]       acc_r;
  logic [MAG_W-1:0]       wres_r;
  logic [MAG_W-1:0]       pvel_r;
  logic [MAG_W-1:0]       spring_r;

  // norm clamp
  logic [MAG_W-1:0]       mag_r  [3];
  logic [2:0]             negf_r;
  logic                   shifted_r;
  logic [MAG_W-1:0]       sq_r;
  logic [61:0]            lsq_r;
  logic [MUL_W-1:0]       n_r;
  logic [MUL_W-1:0]       fmag_r [3];

  // output register
  logic                   out_valid_r;
  logic [FORCE_W-1:0]     force_r [3];
  logic [COORD_WIDTH-1:0] oprox_r [3];
  logic                   wrench_r;
  logic [OBJ_W-1:0]       target_r;

  // shared units
  logic [MUL_W-1:0]       mul_a;
  logic [MUL_W-1:0]       mul_b;
  logic [2*MUL_W-1:0]     mul_p;
  ds_ctrl_t               ds_ctrl;
  logic [MAG_W-1:0]       ds_opa;
  logic                   ds_done;
  logic [MUL_W-1:0]       ds_result;

  // combinational helpers
  logic [MAG_W-1:0]       op_sel;
  logic [MAG_W-1:0]       op_mag;
  logic [MUL_W-1:0]       wb;
  logic [ACC_W-1:0]       acc_sh;
  logic                   rnd;
  logic [ACC_W-1:0]       q;
  logic [MAG_W-1:0]       q_sat;
  logic [MAG_W-1:0]       fsum;
  logic [MUL_W-1:0]       sq_opnd;
  logic                   big;
  logic                   clamp;
  logic                   out_free;

  // signed operand of the current wide product
  always_comb begin
    case (term_r)
      T_PV:    op_sel = sx64(proxy_r[ax_r]) - sx64(prev_r[ax_r]);
      T_SP:    op_sel = sx64(proxy_r[ax_r]) - sx64(tool_r[ax_r]);
      T_DM:    op_sel = pvel_r - sx64(tvel_r[ax_r]);
      default: op_sel = '0;
    endcase
    op_mag = op_sel[MAG_W-1] ? (MAG_W'(0) - op_sel) : op_sel;
  end

  // register operand of the current wide product
  always_comb begin
    case (term_r)
      T_PV:    wb = {{(MUL_W-TICK_W){1'b0}}, tick_r};
      T_SP:    wb = {1'b0, stiff_r};
      T_DM:    wb = {1'b0, damp_r};
      default: wb = '0;
    endcase
  end

  // shift, floor rounding and saturation of the accumulated product
  always_comb begin
    acc_sh = (term_r == T_PV) ? acc_r : (acc_r >> FRAC_BITS);
    rnd    = (term_r != T_PV) && wneg_r && (|acc_r[FRAC_BITS-1:0]);
    q      = acc_sh + {{(ACC_W-1){1'b0}}, rnd};
    q_sat  = (q > {{(ACC_W-MAG_W){1'b0}}, SAT_MAG}) ? SAT_MAG : q[MAG_W-1:0];
  end

  assign fsum = spring_r + wres_r;

  // operand for the squares: a force magnitude, or the limit for limit^2
  always_comb begin
    case (k_r)
      2'd0:    sq_opnd = mag_r[0][MUL_W-1:0];
      2'd1:    sq_opnd = mag_r[1][MUL_W-1:0];
      2'd2:    sq_opnd = mag_r[2][MUL_W-1:0];
      default: sq_opnd = {1'b0, limit_r};
    endcase
  end

  assign big = (|mag_r[0][MAG_W-1:REG_W]) || (|mag_r[1][MAG_W-1:REG_W]) ||
               (|mag_r[2][MAG_W-1:REG_W]);
  assign clamp    = shifted_r || (sq_r > {2'b00, lsq_r});
  assign out_free = !out_valid_r || out_ready;

  // multiplier operand steering
  always_comb begin
    case (state_r)
      S_WLO: begin
        mul_a = wmag_r[MUL_W-1:0];
        mul_b = wb;
      end
      S_WHI: begin
        mul_a = wmag_r[MAG_W-1:MUL_W];
        mul_b = wb;
      end
      S_SQI: begin
        mul_a = sq_opnd;
        mul_b = sq_opnd;
      end
      S_DMUL: begin
        mul_a = mag_r[ax_r][MUL_W-1:0];
        mul_b = {1'b0, limit_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divide / square root commands
  always_comb begin
    ds_ctrl.start = 1'b0;
    ds_ctrl.op    = OP_DIV;
    ds_opa        = mul_p;
    if (state_r == S_CMP && clamp) begin
      ds_ctrl.start = 1'b1;
      ds_ctrl.op    = OP_SQRT;
      ds_opa        = sq_r;
    end else if (state_r == S_DSTART) begin
      ds_ctrl.start = 1'b1;
    end
  end

  hpcf_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  hpcf_divsqrt u_divsqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ds_ctrl),
    .opa    (ds_opa),
    .opb    (n_r),
    .done   (ds_done),
    .result (ds_result)
  );

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      term_r      <= T_PV;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      stiff_r     <= K_RST;
      damp_r      <= D_RST;
      limit_r     <= L_RST;
      tick_r      <= TICK_RST;
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          REG_STIFFNESS: stiff_r <= cfg_wdata;
          REG_DAMPING:   damp_r  <= cfg_wdata;
          REG_FORCE_LIM: limit_r <= cfg_wdata;
          REG_TICK_RATE: tick_r  <= cfg_wdata[TICK_W-1:0];
          default: ;
        endcase
      end

      // result taken; a new one loaded from S_OUT in the same cycle wins
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            tool_r[0]  <= in_tool_px;
            tool_r[1]  <= in_tool_py;
            tool_r[2]  <= in_tool_pz;
            tvel_r[0]  <= in_tool_vx;
            tvel_r[1]  <= in_tool_vy;
            tvel_r[2]  <= in_tool_vz;
            proxy_r[0] <= in_in_contact ? in_contact_cx : in_tool_px;
            proxy_r[1] <= in_in_contact ? in_contact_cy : in_tool_py;
            proxy_r[2] <= in_in_contact ? in_contact_cz : in_tool_pz;
            contact_r  <= in_in_contact;
            object_r   <= in_contact_object;
            shifted_r  <= 1'b0;
            ax_r       <= '0;
            term_r     <= T_PV;
            state_r    <= S_WSET;
          end
        end
        S_WSET: begin
          wmag_r  <= op_mag;
          wneg_r  <= op_sel[MAG_W-1];
          state_r <= S_WLO;
        end
        S_WLO: begin
          state_r <= S_WHI;
        end
        S_WHI: begin
          acc_r   <= {{(ACC_W-2*MUL_W){1'b0}}, mul_p};
          state_r <= S_WACC;
        end
        S_WACC: begin
          acc_r   <= acc_r + {mul_p, {MUL_W{1'b0}}};
          state_r <= S_WFIN;
        end
        S_WFIN: begin
          wres_r  <= wneg_r ? (MAG_W'(0) - q_sat) : q_sat;
          state_r <= S_WUSE;
        end
        S_WUSE: begin
          state_r <= S_WSET;
          case (term_r)
            T_PV: begin
              pvel_r <= wres_r;
              term_r <= T_SP;
            end
            T_SP: begin
              spring_r <= wres_r;
              term_r   <= T_DM;
            end
            default: begin
              // force = spring + damper, kept as sign and magnitude
              negf_r[ax_r] <= fsum[MAG_W-1];
              mag_r[ax_r]  <= fsum[MAG_W-1] ? (MAG_W'(0) - fsum) : fsum;
              term_r       <= T_PV;
              if (ax_r == AX_LAST) begin
                ax_r    <= '0;
                state_r <= S_SHIFT;
              end else begin
                ax_r <= ax_r + 1'b1;
              end
            end
          endcase
        end
        S_SHIFT: begin
          // bring every magnitude below 2^31, one bit per cycle
          if (big) begin
            for (int i = 0; i < 3; i++) begin
              mag_r[i] <= mag_r[i] >> 1;
            end
            shifted_r <= 1'b1;
          end else begin
            k_r     <= '0;
            sq_r    <= '0;
            state_r <= S_SQI;
          end
        end
        S_SQI: begin
          state_r <= S_SQA;
        end
        S_SQA: begin
          if (k_r == K_LIM) begin
            lsq_r   <= mul_p[61:0];
            state_r <= S_CMP;
          end else begin
            sq_r    <= sq_r + mul_p;
            k_r     <= k_r + 1'b1;
            state_r <= S_SQI;
          end
        end
        S_CMP: begin
          if (clamp) begin
            state_r <= S_SQRT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              fmag_r[i] <= mag_r[i][MUL_W-1:0];
            end
            state_r <= S_OUT;
          end
        end
        S_SQRT: begin
          if (ds_done) begin
            n_r     <= ds_result;
            ax_r    <= '0;
            state_r <= S_DMUL;
          end
        end
        S_DMUL: begin
          state_r <= S_DSTART;
        end
        S_DSTART: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          // scaled magnitude = |F| * limit / norm
          if (ds_done) begin
            fmag_r[ax_r] <= ds_result;
            if (ax_r == AX_LAST) begin
              ax_r    <= '0;
              state_r <= S_OUT;
            end else begin
              ax_r    <= ax_r + 1'b1;
              state_r <= S_DMUL;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            for (int i = 0; i < 3; i++) begin
              force_r[i] <= negf_r[i] ? (FORCE_W'(0) - fmag_r[i]) : fmag_r[i];
              oprox_r[i] <= proxy_r[i];
              prev_r[i]  <= proxy_r[i];
            end
            wrench_r    <= contact_r && (object_r != '0);
            target_r    <= (contact_r && (object_r != '0)) ? object_r : '0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_force_x       = force_r[0];
  assign out_force_y       = force_r[1];
  assign out_force_z       = force_r[2];
  assign out_proxy_x       = oprox_r[0];
  assign out_proxy_y       = oprox_r[1];
  assign out_proxy_z       = oprox_r[2];
  assign out_wrench_valid  = wrench_r;
  assign out_target_object = target_r;

`ifndef SYNTH
  // an accepted transaction keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a transaction was in progress");

  // the divide / square root unit only finishes when the sequencer waits on it
  a_ds_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    ds_done |-> (state_r == S_SQRT || state_r == S_DIV))
    else $error("divide/sqrt completion outside a wait state");

  // a clamped component never exceeds the force limit
  a_clamp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && ds_done) |-> (ds_result <= {1'b0, limit_r}))
    else $error("scaled force magnitude above the limit");

  // a wrench goes out exactly when a target object is named
  a_wrench_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_wrench_valid == (out_target_object != '0)))
    else $error("wrench valid does not match target object");
`endif

endmodule

>>> dv/haptic_proxy_coupling_force_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haptic_proxy_coupling_force_test: self-checking bench for the coupling force
// Drives servo ticks through the valid/ready input channel and checks each
// wrench against a cycle-free predictor of the spring-damper force with its
// norm clamp. Directed corner ticks come first, then random ticks under
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module haptic_proxy_coupling_force_test;
  import hpcf_pkg::*;

  localparam int COORD_W       = 32;
  localparam int FRAC          = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 300;
  localparam int PHASES        = 8;
  localparam int PHASE_TICKS   = 88;

  // one servo tick; index 0/1/2 is axis x/y/z
  typedef struct packed {
    logic [2:0][COORD_W-1:0] tool_p;
    logic [2:0][COORD_W-1:0] tool_v;
    logic                    contact;
    logic [2:0][COORD_W-1:0] contact_c;
    logic [OBJ_W-1:0]        object_id;
  } servo_tick_t;

  // one wrench result
  typedef struct packed {
    logic [2:0][FORCE_W-1:0] force_v;
    logic [2:0][COORD_W-1:0] proxy;
    logic                    wrench_valid;
    logic [OBJ_W-1:0]        target;
  } wrench_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the wrench of each accepted tick, checks results
  // --------------------------------------------------------------------------
  class coupling_scoreboard;
    logic [REG_W-1:0]  stiffness;
    logic [REG_W-1:0]  damping;
    logic [REG_W-1:0]  force_limit;
    logic [TICK_W-1:0] tick_rate;
    longint            prev_proxy[3];
    wrench_t           wrench_q[$];
    int                errors;

    function new();
      stiffness   = REG_W'(2000 << FRAC);
      damping     = REG_W'(28 << FRAC);
      force_limit = REG_W'(15 << FRAC);
      tick_rate   = TICK_W'(1000);
      for (int i = 0; i < 3; i++) prev_proxy[i] = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [REG_W-1:0] value);
      case (idx)
        REG_STIFFNESS: stiffness = value;
        REG_DAMPING:   damping = value;
        REG_FORCE_LIM: force_limit = value;
        REG_TICK_RATE: tick_rate = value[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return wrench_q.size();
    endfunction

    // (a * b) >> sh, rounded toward minus infinity, saturated to +-SAT_MAG
    function longint scaled_product(longint a, longint unsigned b, int sh);
      logic [127:0]    prod;
      logic [127:0]    q;
      longint unsigned m;
      logic            neg;
      neg = (a < 0);
      m = a;
      if (neg) m = -a;
      prod = {64'd0, m} * {64'd0, b};
      q = prod >> sh;
      if (neg && ((prod & ((128'd1 << sh) - 128'd1)) != 128'd0)) q = q + 128'd1;
      if (q > {64'd0, SAT_MAG}) q = {64'd0, SAT_MAG};
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // digit-by-digit floor square root
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned bitv;
      rem = v;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= root + bitv) begin
          rem = rem - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return root;
    endfunction

    function void note_input(servo_tick_t t);
      longint          proxy_pos[3];
      longint          tool;
      longint          tvel;
      longint          pvel;
      longint          spring;
      longint          damp;
      longint          f;
      longint unsigned mag[3];
      longint unsigned r[3];
      longint unsigned peak;
      longint unsigned sq;
      longint unsigned lim;
      longint unsigned root;
      longint unsigned tmp;
      logic            negf[3];
      int              sh;
      wrench_t         w;
      peak = 0;
      sq = 0;
      lim = force_limit;
      // raw spring-damper force per axis
      for (int i = 0; i < 3; i++) begin
        tool = $signed(t.tool_p[i]);
        tvel = $signed(t.tool_v[i]);
        if (t.contact) proxy_pos[i] = $signed(t.contact_c[i]);
        else proxy_pos[i] = tool;
        pvel = scaled_product(proxy_pos[i] - prev_proxy[i], tick_rate, 0);
        spring = scaled_product(proxy_pos[i] - tool, stiffness, FRAC);
        damp = scaled_product(pvel - tvel, damping, FRAC);
        f = spring + damp;
        negf[i] = (f < 0);
        mag[i] = negf[i] ? -f : f;
        if (mag[i] > peak) peak = mag[i];
      end
      // bring magnitudes under 2^31; a nonzero shift forces the clamp
      sh = 0;
      while ((peak >> sh) >= 64'h8000_0000) sh++;
      for (int i = 0; i < 3; i++) begin
        r[i] = mag[i] >> sh;
        sq = sq + r[i] * r[i];
      end
      if (sh > 0 || sq > lim * lim) begin
        root = root_floor(sq);
        for (int i = 0; i < 3; i++) mag[i] = (root == 0) ? 0 : (r[i] * lim) / root;
      end
      for (int i = 0; i < 3; i++) begin
        tmp = negf[i] ? (64'd0 - mag[i]) : mag[i];
        w.force_v[i] = tmp[FORCE_W-1:0];
        w.proxy[i] = proxy_pos[i][COORD_W-1:0];
        prev_proxy[i] = proxy_pos[i];
      end
      w.wrench_valid = t.contact && (t.object_id != 0);
      w.target = w.wrench_valid ? t.object_id : '0;
      wrench_q.push_back(w);
    endfunction

    function void check_result(wrench_t r);
      wrench_t e;
      if (wrench_q.size() == 0) begin
        $error("wrench with no tick outstanding");
        errors++;
        return;
      end
      e = wrench_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (r.force_v[i] !== e.force_v[i]) begin
          $error("force_%c: expected %0d, actual %0d", 8'h78 + i,
                 $signed(e.force_v[i]), $signed(r.force_v[i]));
          errors++;
        end
        if (r.proxy[i] !== e.proxy[i]) begin
          $error("proxy_%c: expected %0d, actual %0d", 8'h78 + i,
                 $signed(e.proxy[i]), $signed(r.proxy[i]));
          errors++;
        end
      end
      if (r.wrench_valid !== e.wrench_valid) begin
        $error("wrench_valid: expected %0b, actual %0b", e.wrench_valid, r.wrench_valid);
        errors++;
      end
      if (r.target !== e.target) begin
        $error("target_object: expected %0d, actual %0d", e.target, r.target);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and channel signals
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [1:0]           cfg_index;
  logic [REG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  servo_tick_t          in_tick;
  logic                 out_valid;
  logic                 out_ready;
  wrench_t              out_wrench;
  logic                 idle_on;
  logic [COORD_W-1:0]   walk [3];
  int                   cycle_count;
  coupling_scoreboard   sb;

  always #2 clk = ~clk;

  haptic_proxy_coupling_force #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (FRAC)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_tool_px       (in_tick.tool_p[0]),
    .in_tool_py       (in_tick.tool_p[1]),
    .in_tool_pz       (in_tick.tool_p[2]),
    .in_tool_vx       (in_tick.tool_v[0]),
    .in_tool_vy       (in_tick.tool_v[1]),
    .in_tool_vz       (in_tick.tool_v[2]),
    .in_in_contact    (in_tick.contact),
    .in_contact_cx    (in_tick.contact_c[0]),
    .in_contact_cy    (in_tick.contact_c[1]),
    .in_contact_cz    (in_tick.contact_c[2]),
    .in_contact_object(in_tick.object_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_force_x      (out_wrench.force_v[0]),
    .out_force_y      (out_wrench.force_v[1]),
    .out_force_z      (out_wrench.force_v[2]),
    .out_proxy_x      (out_wrench.proxy[0]),
    .out_proxy_y      (out_wrench.proxy[1]),
    .out_proxy_z      (out_wrench.proxy[2]),
    .out_wrench_valid (out_wrench.wrench_valid),
    .out_target_object(out_wrench.target)
  );

  // result side: random backpressure, changed on the falling edge
  always @(negedge clk) begin
    if (rst_n) out_ready = !(idle_on && $urandom_range(99) < 20);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_wrench);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("haptic_proxy_coupling_force_test: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic servo_tick_t tick_from(
    logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz,
    logic [COORD_W-1:0] vx, logic [COORD_W-1:0] vy, logic [COORD_W-1:0] vz,
    logic contact,
    logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz,
    logic [OBJ_W-1:0] obj);
    servo_tick_t t;
    t.tool_p    = {pz, py, px};
    t.tool_v    = {vz, vy, vx};
    t.contact   = contact;
    t.contact_c = {cz, cy, cx};
    t.object_id = obj;
    return t;
  endfunction

  // symmetric random offset in [-span, span]
  function automatic logic [COORD_W-1:0] jitter(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // mostly a tool wandering near the surface, some fully random ticks
  function automatic servo_tick_t random_tick();
    servo_tick_t t;
    int          span;
    if ($urandom_range(99) < 20) begin
      for (int i = 0; i < 3; i++) begin
        t.tool_p[i]    = $urandom;
        t.tool_v[i]    = $urandom;
        t.contact_c[i] = $urandom;
      end
      t.contact   = 1'($urandom_range(1));
      t.object_id = OBJ_W'($urandom_range(65535));
    end else begin
      case ($urandom_range(3))
        0:       span = 16;
        1:       span = 256;
        2:       span = 4096;
        default: span = 131072;
      endcase
      for (int i = 0; i < 3; i++) begin
        walk[i]        = walk[i] + jitter(span);
        t.tool_p[i]    = walk[i];
        t.tool_v[i]    = jitter(span * 16);
        t.contact_c[i] = walk[i] + jitter(span);
      end
      t.contact   = ($urandom_range(99) < 65);
      t.object_id = ($urandom_range(7) == 0) ? '0 : OBJ_W'($urandom_range(1, 65535));
    end
    return t;
  endfunction

  // present one tick and hold it until accepted; returns on a falling edge
  task automatic send_tick(servo_tick_t t);
    while (idle_on && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_tick  = t;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(t);
    @(negedge clk);
  endtask

  // wait for every outstanding wrench, then a short quiet pause
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // write all four registers back to back; block must be idle
  task automatic apply_settings(logic [REG_W-1:0] k, logic [REG_W-1:0] d,
                                logic [REG_W-1:0] lim, logic [REG_W-1:0] rate);
    cfg_we    = 1'b1;
    cfg_index = REG_STIFFNESS;
    cfg_wdata = k;
    sb.set_reg(REG_STIFFNESS, k);
    @(negedge clk);
    cfg_index = REG_DAMPING;
    cfg_wdata = d;
    sb.set_reg(REG_DAMPING, d);
    @(negedge clk);
    cfg_index = REG_FORCE_LIM;
    cfg_wdata = lim;
    sb.set_reg(REG_FORCE_LIM, lim);
    @(negedge clk);
    cfg_index = REG_TICK_RATE;
    cfg_wdata = rate;
    sb.set_reg(REG_TICK_RATE, rate);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  localparam logic [REG_W-1:0] REG_MAX = '1;

  initial begin
    sb          = new();
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_STIFFNESS;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_tick     = '0;
    out_ready   = 1'b0;
    idle_on     = 1'b1;
    cycle_count = 0;
    for (int i = 0; i < 3; i++) walk[i] = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed ticks under the reset register values
    send_tick(tick_from(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick_from(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0));
    send_tick(tick_from(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 16'hFFFF));
    // contact with object id zero: proxy follows, no wrench target
    send_tick(tick_from(0, 0, 0, 0, 0, 0, 1, 100, -100, 50, 0));
    send_tick(tick_from(1000, 2000, 3000, 0, 0, 0, 1, 1000, 2000, 3000, 1));
    // proxy at rest on the tool: zero force
    send_tick(tick_from(1000, 2000, 3000, 0, 0, 0, 1, 1000, 2000, 3000, 1));
    send_tick(tick_from(1000, 2000, 3000, 0, 0, 0, 1, 1300, 2000, 3000, 7));
    // contact point ignored without contact
    send_tick(tick_from(1000, 2000, 3000, -65536, 65536, 0, 0, 32'hAAAA_AAAA,
                        32'hAAAA_AAAA, 32'hAAAA_AAAA, 16'h1234));
    send_tick(tick_from(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                        32'h5555_5555, 32'h5555_5555, 1, 32'h5555_5555, 32'h5555_5555,
                        32'h5555_5555, 16'h5555));
    send_tick(tick_from(32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                        32'hAAAA_AAAA, 32'hAAAA_AAAA, 0, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                        32'hAAAA_AAAA, 16'hAAAA));
    send_tick(tick_from(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                        0, 0, 0, 1));
    // small negative offsets exercise floor rounding
    send_tick(tick_from(0, 0, 0, 0, 0, 0, 1, 1, -1, 1, 2));
    settle();

    // zero force limit and zero tick rate
    apply_settings(REG_W'(2000 << FRAC), REG_W'(28 << FRAC), '0, '0);
    send_tick(tick_from(500, 600, 700, 100, 200, 300, 0, 0, 0, 0, 0));
    send_tick(tick_from(500, 600, 700, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tick(tick_from(500, 600, 700, 40, -40, 0, 1, 900, 100, 700, 3));
    settle();

    // stiffness, damping and force limit at their top values, tick rate at 1000000
    apply_settings(REG_MAX, REG_MAX, REG_MAX, REG_W'(1000000));
    send_tick(tick_from(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 1,
                        32'h7FFF_FFFF, 32'h8000_0000, 0, 16'h8001));
    send_tick(tick_from(1, 1, 1, 0, 0, 0, 1, 2, 1, 1, 9));
    send_tick(tick_from(1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 9));
    settle();

    // random ticks, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(REG_W'(2000 << FRAC), REG_W'(28 << FRAC), REG_W'(15 << FRAC),
                          REG_W'(1000));
        1: apply_settings(REG_MAX, REG_MAX, REG_MAX, REG_W'(1000000));
        2: apply_settings('0, '0, REG_W'($urandom), REG_W'(1));
        3, 7: apply_settings(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom),
                             REG_W'($urandom_range(1, 1000000)));
        6: apply_settings(REG_MAX, '0, REG_W'(1), REG_W'(1000000));
        default: apply_settings(REG_W'($urandom_range(1, 1 << 24)),
                                REG_W'($urandom_range(0, 1 << 20)),
                                REG_W'($urandom_range(1 << 12, 1 << 22)),
                                REG_W'($urandom_range(100, 10000)));
      endcase
      // one phase runs without any idling on either channel
      idle_on = (p != 5);
      for (int n = 0; n < PHASE_TICKS; n++) send_tick(random_tick());
      settle();
    end
    idle_on = 1'b1;

    // drain and let any stray wrench show up
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("haptic_proxy_coupling_force_test: clean");
    end else begin
      $display("haptic_proxy_coupling_force_test: errors");
    end
    $finish;
  end

endmodule
